FILE: rtl/i2p_pkg.sv
// Shared types, character codes and the precedence table of the infix to postfix converter.
package i2p_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_P     = 8'h70;  // held form of unary plus
  localparam logic [7:0] CH_M     = 8'h6D;  // held form of unary minus
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;

  localparam logic [2:0] PREC_UNARY = 3'd6;
  localparam logic [2:0] PREC_MUL   = 3'd5;
  localparam logic [2:0] PREC_ADD   = 3'd4;
  localparam logic [2:0] PREC_CMP   = 3'd3;
  localparam logic [2:0] PREC_AND   = 3'd2;
  localparam logic [2:0] PREC_OR    = 3'd1;
  localparam logic [2:0] PREC_NONE  = 3'd0;

  localparam logic [2:0] KIND_CHAR      = 3'd0;
  localparam logic [2:0] KIND_OVERFLOW  = 3'd1;
  localparam logic [2:0] KIND_UNMATCHED = 3'd2;
  localparam logic [2:0] KIND_END       = 3'd3;
  localparam logic [2:0] KIND_BAD       = 3'd4;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_OPERAND,
    CMD_BAD,
    CMD_OP,
    CMD_CLOSE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
    logic [2:0] prec;
    logic       pops;
    logic       fin;
  } cmd_t;

  function automatic logic [2:0] op_prec(input logic [7:0] c);
    logic [2:0] p;
    unique case (c)
      CH_BANG, CH_P, CH_M: p = PREC_UNARY;
      CH_STAR, CH_SLASH:   p = PREC_MUL;
      CH_PLUS, CH_MINUS:   p = PREC_ADD;
      CH_GT, CH_LT:        p = PREC_CMP;
      CH_AMP:              p = PREC_AND;
      CH_BAR:              p = PREC_OR;
      default:             p = PREC_NONE;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/infix_to_postfix_converter_unit.sv
// Top level of the infix to postfix converter: front end, command queue and stack engine.
// A result passes through the command queue, the stack engine's hold stage and the output register.
// The front end takes a new character while the queue has room and stalls the input when it is full;
// the stack engine pops results from the stack before it takes the next command.
// A final character also pops every result of the remaining stack and then gives the end marker.
// Reset (rst_n low, synchronous) empties the queue, the stack and the output register.
module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_final_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic [2:0] out_kind,
  output logic       out_run_end
);
  import i2p_pkg::*;

  // The front end tracks what came before each character (start, operand or operator)
  // and any half of a doubled logic operator, so it alone decides unary signs and
  // whether a logic character is a push or only a record.
  logic wr_en;
  cmd_t wr_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  i2p_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_char       (in_char),
    .in_final_char (in_final_char),
    .q_full        (q_full),
    .in_stall      (in_stall),
    .wr_en         (wr_en),
    .wr_cmd        (wr_cmd)
  );

  // The queue lets the front end keep taking beats while the stack engine pops.
  i2p_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_cmd   (wr_cmd),
    .rd_en    (q_pop),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd)
  );

  // The stack engine keeps each new result in a hold stage until it knows whether
  // another result of the same character follows; that decides the run_end flag.
  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .out_kind    (out_kind),
    .out_run_end (out_run_end)
  );

endmodule

FILE: rtl/i2p_front.sv
// Front end: classifies each input character into a command for the stack engine.
module i2p_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_char,
  input  logic          in_final_char,
  input  logic          q_full,
  output logic          in_stall,
  output logic          wr_en,
  output i2p_pkg::cmd_t wr_cmd
);
  import i2p_pkg::*;

  localparam logic [1:0] CLS_START    = 2'd0;
  localparam logic [1:0] CLS_OPERAND  = 2'd1;
  localparam logic [1:0] CLS_OPERATOR = 2'd2;

  logic [1:0] prev_class_r, prev_class_nxt;
  logic [7:0] pending_r, pending_nxt;
  logic [7:0] c_map;
  logic       is_oper;
  logic       is_logic;
  cmd_t       cmd;

  assign in_stall = q_full;
  assign wr_en    = in_valid && !q_full;
  assign wr_cmd   = cmd;

  always_comb begin
    is_oper = (in_char == CH_BANG) || (in_char == CH_STAR) || (in_char == CH_SLASH) ||
              (in_char == CH_PLUS) || (in_char == CH_MINUS) || (in_char == CH_GT) ||
              (in_char == CH_LT) || (in_char == CH_AMP) || (in_char == CH_BAR);
    c_map = in_char;
    if (((in_char == CH_PLUS) || (in_char == CH_MINUS)) && (prev_class_r != CLS_OPERAND)) begin
      c_map = (in_char == CH_PLUS) ? CH_P : CH_M;
    end
    is_logic = (c_map == CH_AMP) || (c_map == CH_BAR);
  end

  always_comb begin
    cmd            = '0;
    cmd.kind       = CMD_BAD;
    cmd.fin        = in_final_char;
    prev_class_nxt = prev_class_r;
    pending_nxt    = pending_r;
    priority if ((in_char >= CH_A) && (in_char <= CH_Z)) begin
      cmd.kind       = CMD_OPERAND;
      cmd.ch         = in_char;
      prev_class_nxt = CLS_OPERAND;
    end else if (in_char == CH_OPEN) begin
      cmd.kind       = CMD_OP;
      cmd.ch         = CH_OPEN;
      cmd.prec       = PREC_NONE;
      cmd.pops       = 1'b0;
      prev_class_nxt = CLS_OPERATOR;
    end else if (in_char == CH_CLOSE) begin
      cmd.kind       = CMD_CLOSE;
      prev_class_nxt = CLS_OPERAND;
    end else if (is_oper) begin
      if (is_logic && (c_map != pending_r)) begin
        cmd.kind    = CMD_NONE;
        pending_nxt = c_map;
      end else begin
        cmd.kind = CMD_OP;
        cmd.ch   = c_map;
        cmd.prec = op_prec(c_map);
        cmd.pops = (op_prec(c_map) < PREC_UNARY);
        if (is_logic) begin
          pending_nxt = '0;
        end
      end
      prev_class_nxt = CLS_OPERATOR;
    end else begin
      cmd.kind = CMD_BAD;
    end
    if (in_final_char) begin
      pending_nxt    = '0;
      prev_class_nxt = CLS_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_class_r <= CLS_START;
      pending_r    <= '0;
    end else if (wr_en) begin
      prev_class_r <= prev_class_nxt;
      pending_r    <= pending_nxt;
    end
  end

endmodule

FILE: rtl/i2p_queue.sv
// Small command queue between the front end and the stack engine.
module i2p_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  i2p_pkg::cmd_t wr_cmd,
  input  logic          rd_en,
  output logic          full,
  output logic          rd_valid,
  output i2p_pkg::cmd_t rd_cmd
);
  import i2p_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full     = (cnt_r == CW'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

FILE: rtl/i2p_back.sv
// Back end: operator stack sequencer with a one-result hold stage and the output register.
module i2p_back #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  i2p_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_char,
  output logic [2:0]    out_kind,
  output logic          out_run_end
);
  import i2p_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EMIT1  = 8'b0000_0010,
    S_POP    = 8'b0000_0100,
    S_PUSH   = 8'b0000_1000,
    S_CLOSE  = 8'b0001_0000,
    S_SECOND = 8'b0010_0000,
    S_FLUSH  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t        state_r, state_nxt, ret_r, ret_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [7:0]    stack_r [STACK_DEPTH];
  logic [CW-1:0] count_r, count_nxt, count_m1;
  logic [IW-1:0] top_idx;
  logic [7:0]    top;
  logic [2:0]    top_prec;
  logic [7:0]    second_r, second_nxt;
  logic [7:0]    pe_ch;
  logic [2:0]    pe_kind;
  logic          pe_double;
  logic          push;
  logic          emit, emit_ok, finish, out_free, move;
  logic [7:0]    emit_ch;
  logic [2:0]    emit_kind;
  logic          hold_valid_r;
  logic [7:0]    hold_ch_r;
  logic [2:0]    hold_kind_r;
  logic          out_valid_r, out_run_end_r;
  logic [7:0]    out_char_r;
  logic [2:0]    out_kind_r;
  state_t        after_cmd;

  assign count_m1 = count_r - CW'(1);
  assign top_idx  = count_m1[IW-1:0];
  assign top      = stack_r[top_idx];
  assign top_prec = op_prec(top);
  assign after_cmd = cmd_r.fin ? S_FLUSH : S_DONE;

  // Output mapping of a popped entry.
  always_comb begin
    pe_ch     = top;
    pe_kind   = KIND_CHAR;
    pe_double = 1'b0;
    priority if ((top == CH_AMP) || (top == CH_BAR)) begin
      pe_double = 1'b1;
    end else if (top == CH_P) begin
      pe_ch = CH_PLUS;
    end else if (top == CH_M) begin
      pe_ch = CH_MINUS;
    end else if (top == CH_OPEN) begin
      pe_ch   = '0;
      pe_kind = KIND_UNMATCHED;
    end else begin
      pe_ch = top;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign emit_ok  = !hold_valid_r || out_free;

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    cmd_nxt    = cmd_r;
    count_nxt  = count_r;
    second_nxt = second_r;
    q_pop      = 1'b0;
    push       = 1'b0;
    emit       = 1'b0;
    emit_ch    = '0;
    emit_kind  = KIND_CHAR;
    finish     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          unique case (q_cmd.kind)
            CMD_OPERAND, CMD_BAD: state_nxt = S_EMIT1;
            CMD_OP:               state_nxt = S_POP;
            CMD_CLOSE:            state_nxt = S_CLOSE;
            default:              state_nxt = q_cmd.fin ? S_FLUSH : S_DONE;
          endcase
        end
      end
      S_EMIT1: begin
        emit = 1'b1;
        if (cmd_r.kind == CMD_OPERAND) begin
          emit_ch = cmd_r.ch;
        end else begin
          emit_kind = KIND_BAD;
        end
        if (emit_ok) begin
          state_nxt = after_cmd;
        end
      end
      S_POP: begin
        if (cmd_r.pops && (count_r != '0) && (cmd_r.prec <= top_prec)) begin
          emit      = 1'b1;
          emit_ch   = pe_ch;
          emit_kind = pe_kind;
          if (emit_ok) begin
            count_nxt = count_m1;
            if (pe_double) begin
              second_nxt = top;
              ret_nxt    = S_POP;
              state_nxt  = S_SECOND;
            end
          end
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (count_r == CW'(STACK_DEPTH)) begin
          emit      = 1'b1;
          emit_kind = KIND_OVERFLOW;
          if (emit_ok) begin
            state_nxt = after_cmd;
          end
        end else begin
          push      = 1'b1;
          count_nxt = count_r + CW'(1);
          state_nxt = after_cmd;
        end
      end
      S_CLOSE: begin
        if (count_r == '0) begin
          emit      = 1'b1;
          emit_kind = KIND_UNMATCHED;
          if (emit_ok) begin
            state_nxt = after_cmd;
          end
        end else if (top == CH_OPEN) begin
          count_nxt = count_m1;
          state_nxt = after_cmd;
        end else begin
          emit      = 1'b1;
          emit_ch   = pe_ch;
          emit_kind = pe_kind;
          if (emit_ok) begin
            count_nxt = count_m1;
            if (pe_double) begin
              second_nxt = top;
              ret_nxt    = S_CLOSE;
              state_nxt  = S_SECOND;
            end
          end
        end
      end
      S_SECOND: begin
        emit    = 1'b1;
        emit_ch = second_r;
        if (emit_ok) begin
          state_nxt = ret_r;
        end
      end
      S_FLUSH: begin
        emit = 1'b1;
        if (count_r != '0) begin
          emit_ch   = pe_ch;
          emit_kind = pe_kind;
          if (emit_ok) begin
            count_nxt = count_m1;
            if (pe_double) begin
              second_nxt = top;
              ret_nxt    = S_FLUSH;
              state_nxt  = S_SECOND;
            end
          end
        end else begin
          emit_kind = KIND_END;
          if (emit_ok) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        finish = hold_valid_r;
        if (!hold_valid_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The held result moves on when a newer one arrives (not last) or the command ends (last).
  assign move = (emit && emit_ok && hold_valid_r) || (finish && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      count_r      <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      count_r <= count_nxt;
      if (emit && emit_ok) begin
        hold_valid_r <= 1'b1;
      end else if (finish && out_free) begin
        hold_valid_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    second_r <= second_nxt;
    if (push) begin
      stack_r[count_r[IW-1:0]] <= cmd_r.ch;
    end
    if (emit && emit_ok) begin
      hold_ch_r   <= emit_ch;
      hold_kind_r <= emit_kind;
    end
    if (move) begin
      out_char_r    <= hold_ch_r;
      out_kind_r    <= hold_kind_r;
      out_run_end_r <= finish;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign out_kind    = out_kind_r;
  assign out_run_end = out_run_end_r;

endmodule

FILE: rtl/i2p_checker.sv
// Port-level checker for the infix to postfix converter and its bind statement.
module i2p_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic [2:0] out_kind,
  input logic       out_run_end
);
  import i2p_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_kind) &&
      $stable(out_run_end))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_CHAR) |-> (out_char == 8'h00))
    else $error("status result carries a character");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_END) |-> out_run_end)
    else $error("end marker is not the last result of its beat");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind <= KIND_BAD))
    else $error("result kind out of range");

endmodule

bind infix_to_postfix_converter_unit i2p_checker u_i2p_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_char    (out_char),
  .out_kind    (out_kind),
  .out_run_end (out_run_end)
);
